FILE: design/pvpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvpc_pkg
// Shared constants, types and the sine table generator for the phase voltage
// to PWM compare pipeline.
// ----------------------------------------------------------------------------
package pvpc_pkg;

  localparam int ANGLE_BITS_DEF      = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SINE_W              = 17;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};

  typedef logic signed [SINE_W-1:0] sine_t;

  typedef struct packed {
    logic               limited;
    logic signed [15:0] d;
    logic signed [15:0] q;
    logic [30:0]        num_d;
    logic [30:0]        num_q;
    sine_t              sn;
    sine_t              cs;
  } sq_tag_t;

  typedef struct packed {
    logic               limited;
    logic signed [15:0] d;
    sine_t              sn;
    sine_t              cs;
  } scale_tag_t;

  typedef struct packed {
    logic nonpos;
    logic over;
  } cmp_flag_t;

  typedef struct packed {
    logic      limited;
    cmp_flag_t flag;
  } cmp_tag_t;

  // Quarter-wave sine in Q15 from a Taylor series in Q30.
  function automatic logic [15:0] quarter_sine(input logic [63:0] r, input int tbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (r * TWO_PI_Q30) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32768) begin
      sum = 64'sd32768;
    end
    return sum[15:0];
  endfunction

endpackage

FILE: design/pvpc_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvpc_sine_rom
// Quarter-wave sine ROM with two registered read ports for sine and cosine.
// ----------------------------------------------------------------------------
module pvpc_sine_rom import pvpc_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [SINE_TABLE_BITS-1:0] idx,
  output sine_t                      sin_val,
  output sine_t                      cos_val
);

  localparam int TB      = SINE_TABLE_BITS;
  localparam int QUARTER = 1 << (TB - 2);
  localparam int AW      = TB - 1;

  typedef logic [15:0] qtab_t [QUARTER+1];

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int k = 0; k <= QUARTER; k++) begin
      tab[k] = quarter_sine(64'(k), TB);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  function automatic logic [AW-1:0] fold(input logic [TB-1:0] i);
    logic [AW-1:0] r;
    r = AW'(i[TB-3:0]);
    return i[TB-2] ? (AW'(QUARTER) - r) : r;
  endfunction

  logic [TB-1:0] cos_idx;
  logic [15:0]   sin_mag_r;
  logic [15:0]   cos_mag_r;
  logic          sin_neg_r;
  logic          cos_neg_r;

  assign cos_idx = idx + TB'(QUARTER);

  always_ff @(posedge clk) begin
    if (en) begin
      sin_mag_r <= QTAB[fold(idx)];
      cos_mag_r <= QTAB[fold(cos_idx)];
      sin_neg_r <= idx[TB-1];
      cos_neg_r <= cos_idx[TB-1];
    end
  end

  assign sin_val = sin_neg_r ? -$signed({1'b0, sin_mag_r}) : $signed({1'b0, sin_mag_r});
  assign cos_val = cos_neg_r ? -$signed({1'b0, cos_mag_r}) : $signed({1'b0, cos_mag_r});

endmodule

FILE: design/pvpc_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvpc_isqrt
// Pipelined integer square root, one root bit per stage, with sideband tag.
// ----------------------------------------------------------------------------
module pvpc_isqrt import pvpc_pkg::*; #(
  parameter int RAD_W  = 50,
  parameter int ROOT_W = 25,
  parameter int TAG_W  = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int CMP_W = ((RAD_W > 2 * ROOT_W) ? RAD_W : 2 * ROOT_W) + 1;

  logic              valid_r [ROOT_W];
  logic [RAD_W-1:0]  rem_r   [ROOT_W];
  logic [ROOT_W-1:0] root_r  [ROOT_W];
  logic [TAG_W-1:0]  tag_r   [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int K = ROOT_W - 1 - s;
    logic              valid_in;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [TAG_W-1:0]  tag_in;
    logic [CMP_W-1:0]  trial;
    logic              fit;
    logic [RAD_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (s == 0) begin : g_first
      assign valid_in = in_valid;
      assign rem_in   = in_rad;
      assign root_in  = '0;
      assign tag_in   = in_tag;
    end else begin : g_next
      assign valid_in = valid_r[s-1];
      assign rem_in   = rem_r[s-1];
      assign root_in  = root_r[s-1];
      assign tag_in   = tag_r[s-1];
    end

    assign trial    = (CMP_W'(root_in) << (K + 1)) + (CMP_W'(1) << (2 * K));
    assign fit      = CMP_W'(rem_in) >= trial;
    assign rem_nxt  = fit ? RAD_W'(CMP_W'(rem_in) - trial) : rem_in;
    assign root_nxt = fit ? (root_in | (ROOT_W'(1) << K)) : root_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        tag_r[s]  <= tag_in;
      end
    end
  end

  assign out_valid = valid_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_tag   = tag_r[ROOT_W-1];

endmodule

FILE: design/pvpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvpc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband tag.
// ----------------------------------------------------------------------------
module pvpc_div import pvpc_pkg::*; #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 25,
  parameter int QUO_W = 24,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);

  localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic             valid_r [QUO_W];
  logic [NUM_W-1:0] rem_r   [QUO_W];
  logic [DEN_W-1:0] den_r   [QUO_W];
  logic [QUO_W-1:0] quo_r   [QUO_W];
  logic [TAG_W-1:0] tag_r   [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - 1 - s;
    logic             valid_in;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [TAG_W-1:0] tag_in;
    logic [CMP_W-1:0] trial;
    logic             fit;
    logic [NUM_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    if (s == 0) begin : g_first
      assign valid_in = in_valid;
      assign rem_in   = in_num;
      assign den_in   = in_den;
      assign quo_in   = '0;
      assign tag_in   = in_tag;
    end else begin : g_next
      assign valid_in = valid_r[s-1];
      assign rem_in   = rem_r[s-1];
      assign den_in   = den_r[s-1];
      assign quo_in   = quo_r[s-1];
      assign tag_in   = tag_r[s-1];
    end

    assign trial   = CMP_W'(den_in) << K;
    assign fit     = CMP_W'(rem_in) >= trial;
    assign rem_nxt = fit ? NUM_W'(CMP_W'(rem_in) - trial) : rem_in;
    assign quo_nxt = fit ? (quo_in | (QUO_W'(1) << K)) : quo_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
        quo_r[s] <= quo_nxt;
        tag_r[s] <= tag_in;
      end
    end
  end

  assign out_valid = valid_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_tag   = tag_r[QUO_W-1];

endmodule

FILE: design/phase_voltage_to_pwm_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_voltage_to_pwm_compare
// Inverse Park / inverse Clarke with sinusoidal PWM compare generation.
// ----------------------------------------------------------------------------
// Takes one d/q voltage command and electrical angle per clock while in_ready
// is high and returns three timer compare counts and a vector-limit flag via
// the square root (25 stages), the vector scale dividers (24 stages) and the
// duty dividers (16 stages); throughput is one beat per clock until the skid
// fills. A two-entry output buffer keeps input acceptance going while a
// result waits. Write the configuration registers only while idle.
// ----------------------------------------------------------------------------
module phase_voltage_to_pwm_compare import pvpc_pkg::*; #(
  parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_volt_d,
  input  logic signed [15:0] in_volt_q,
  input  logic [15:0]        in_elec_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_compare_a,
  output logic [15:0]        out_compare_b,
  output logic [15:0]        out_compare_c,
  output logic               out_vector_limited
);

  typedef enum logic [0:0] {
    CFG_SUPPLY = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    logic        limited;
  } result_t;

  localparam logic [14:0]        SUPPLY_RESET = 15'd3072;
  localparam logic [15:0]        PERIOD_RESET = 16'd1000;
  localparam logic signed [17:0] SQRT3_Q16    = 18'sd113512;
  localparam int                 TB           = SINE_TABLE_BITS;

  function automatic logic signed [37:0] trunc24(input logic signed [61:0] x);
    logic signed [61:0] t;
    t = x + (x[61] ? 62'sd16777215 : 62'sd0);
    return 38'(t >>> 24);
  endfunction

  // configuration
  logic [14:0] supply_r;
  logic [15:0] period_r;
  logic [14:0] vs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= SUPPLY_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SUPPLY: supply_r <= cfg_wdata[14:0];
        CFG_PERIOD: period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign vs = (supply_r == '0) ? 15'd1 : supply_r;

  logic advance;
  logic skid_valid_r;

  assign advance  = !skid_valid_r;
  assign in_ready = advance;

  // angle to table index
  logic [ANGLE_BITS-1:0] ang;
  logic [TB-1:0]         tab_idx;

  assign ang = ANGLE_BITS'(in_elec_angle);
  if (ANGLE_BITS >= TB) begin : g_idx_down
    assign tab_idx = ang[ANGLE_BITS-1 -: TB];
  end else begin : g_idx_up
    assign tab_idx = {ang, {(TB - ANGLE_BITS){1'b0}}};
  end

  sine_t rom_sin;
  sine_t rom_cos;

  pvpc_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (advance),
    .idx    (tab_idx),
    .sin_val(rom_sin),
    .cos_val(rom_cos)
  );

  // stage 1: squares and scale numerators
  logic [15:0]        abs_d;
  logic [15:0]        abs_q;
  logic               v1_r;
  logic signed [15:0] d1_r;
  logic signed [15:0] q1_r;
  logic [31:0]        dsq1_r;
  logic [31:0]        qsq1_r;
  logic [30:0]        num_d1_r;
  logic [30:0]        num_q1_r;
  logic [29:0]        vssq1_r;

  assign abs_d = in_volt_d[15] ? 16'(-in_volt_d) : 16'(in_volt_d);
  assign abs_q = in_volt_q[15] ? 16'(-in_volt_q) : 16'(in_volt_q);

  // stage 2
  logic               v2_r;
  logic signed [15:0] d2_r;
  logic signed [15:0] q2_r;
  logic [31:0]        mag2_2_r;
  logic [29:0]        vssq2_r;
  logic [30:0]        num_d2_r;
  logic [30:0]        num_q2_r;
  sine_t              sn2_r;
  sine_t              cs2_r;

  // stage 3
  logic [33:0]        mag3;
  logic               v3_r;
  logic [49:0]        rad3_r;
  sq_tag_t            tag3_r;

  assign mag3 = {2'b00, mag2_2_r} + {1'b0, mag2_2_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d1_r     <= in_volt_d;
      q1_r     <= in_volt_q;
      dsq1_r   <= abs_d * abs_d;
      qsq1_r   <= abs_q * abs_q;
      num_d1_r <= abs_d * vs;
      num_q1_r <= abs_q * vs;
      vssq1_r  <= vs * vs;

      d2_r     <= d1_r;
      q2_r     <= q1_r;
      mag2_2_r <= dsq1_r + qsq1_r;
      vssq2_r  <= vssq1_r;
      num_d2_r <= num_d1_r;
      num_q2_r <= num_q1_r;
      sn2_r    <= rom_sin;
      cs2_r    <= rom_cos;

      rad3_r         <= {mag3, 16'b0};
      tag3_r.limited <= mag3 > {4'b0, vssq2_r};
      tag3_r.d       <= d2_r;
      tag3_r.q       <= q2_r;
      tag3_r.num_d   <= num_d2_r;
      tag3_r.num_q   <= num_q2_r;
      tag3_r.sn      <= sn2_r;
      tag3_r.cs      <= cs2_r;
    end
  end

  // vector length
  logic        sq_valid;
  logic [24:0] sq_root;
  sq_tag_t     sq_tag;

  pvpc_isqrt #(
    .RAD_W (50),
    .ROOT_W(25),
    .TAG_W ($bits(sq_tag_t))
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (v3_r),
    .in_rad   (rad3_r),
    .in_tag   (tag3_r),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // proportional scaling
  scale_tag_t          sc_tag_in;
  scale_tag_t          sc_tag;
  logic                sc_valid;
  logic [23:0]         quo_d;
  logic [23:0]         quo_q;
  logic signed [15:0]  sc_q;

  assign sc_tag_in.limited = sq_tag.limited;
  assign sc_tag_in.d       = sq_tag.d;
  assign sc_tag_in.sn      = sq_tag.sn;
  assign sc_tag_in.cs      = sq_tag.cs;

  pvpc_div #(
    .NUM_W(47),
    .DEN_W(25),
    .QUO_W(24),
    .TAG_W($bits(scale_tag_t))
  ) u_div_d (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (sq_valid),
    .in_num   ({sq_tag.num_d, 16'b0}),
    .in_den   (sq_root),
    .in_tag   (sc_tag_in),
    .out_valid(sc_valid),
    .out_quo  (quo_d),
    .out_tag  (sc_tag)
  );

  pvpc_div #(
    .NUM_W(47),
    .DEN_W(25),
    .QUO_W(24),
    .TAG_W(16)
  ) u_div_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (sq_valid),
    .in_num   ({sq_tag.num_q, 16'b0}),
    .in_den   (sq_root),
    .in_tag   (sq_tag.q),
    .out_valid(),
    .out_quo  (quo_q),
    .out_tag  (sc_q)
  );

  // stages 4..12: inverse Park, inverse Clarke, duty numerator
  logic signed [24:0] sd_pos;
  logic signed [24:0] sq_pos;
  logic               v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r, v12_r;
  logic               lim4_r, lim5_r, lim6_r, lim7_r, lim8_r, lim9_r, lim10_r;
  logic               lim11_r, lim12_r;
  logic signed [24:0] dv4_r;
  logic signed [24:0] qv4_r;
  sine_t              sn4_r;
  sine_t              cs4_r;
  logic signed [41:0] pdc5_r, pqs5_r, pds5_r, pqc5_r;
  logic signed [42:0] alpha6_r, beta6_r, alpha7_r;
  logic signed [60:0] pb7_r;
  logic signed [61:0] xa8_r, xb8_r, xc8_r;
  logic signed [37:0] ya9_r, yb9_r, yc9_r;
  logic signed [38:0] vs_half;
  logic signed [38:0] sa10_r, sb10_r, sc10_r;
  logic signed [16:0] period_s;
  logic signed [55:0] na11_r, nb11_r, nc11_r;
  logic [39:0]        ma12_r, mb12_r, mc12_r;
  cmp_flag_t          fa12_r, fb12_r, fc12_r;
  logic [39:0]        vs_full;

  assign sd_pos   = $signed({1'b0, quo_d});
  assign sq_pos   = $signed({1'b0, quo_q});
  assign vs_half  = $signed({9'b0, vs, 15'b0});
  assign period_s = $signed({1'b0, period_r});
  assign vs_full  = {9'b0, vs, 16'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
    end else if (advance) begin
      v4_r  <= sc_valid;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lim4_r <= sc_tag.limited;
      if (sc_tag.limited) begin
        dv4_r <= sc_tag.d[15] ? -sd_pos : sd_pos;
        qv4_r <= sc_q[15] ? -sq_pos : sq_pos;
      end else begin
        dv4_r <= $signed({sc_tag.d[15], sc_tag.d, 8'b0});
        qv4_r <= $signed({sc_q[15], sc_q, 8'b0});
      end
      sn4_r <= sc_tag.sn;
      cs4_r <= sc_tag.cs;

      lim5_r <= lim4_r;
      pdc5_r <= dv4_r * cs4_r;
      pqs5_r <= qv4_r * sn4_r;
      pds5_r <= dv4_r * sn4_r;
      pqc5_r <= qv4_r * cs4_r;

      lim6_r   <= lim5_r;
      alpha6_r <= 43'(pdc5_r) - 43'(pqs5_r);
      beta6_r  <= 43'(pds5_r) + 43'(pqc5_r);

      lim7_r   <= lim6_r;
      alpha7_r <= alpha6_r;
      pb7_r    <= beta6_r * SQRT3_Q16;

      lim8_r <= lim7_r;
      xa8_r  <= 62'(alpha7_r) <<< 17;
      xb8_r  <= 62'(pb7_r) - (62'(alpha7_r) <<< 16);
      xc8_r  <= -(62'(alpha7_r) <<< 16) - 62'(pb7_r);

      lim9_r <= lim8_r;
      ya9_r  <= trunc24(xa8_r);
      yb9_r  <= trunc24(xb8_r);
      yc9_r  <= trunc24(xc8_r);

      lim10_r <= lim9_r;
      sa10_r  <= 39'(ya9_r) + vs_half;
      sb10_r  <= 39'(yb9_r) + vs_half;
      sc10_r  <= 39'(yc9_r) + vs_half;

      lim11_r <= lim10_r;
      na11_r  <= period_s * sa10_r;
      nb11_r  <= period_s * sb10_r;
      nc11_r  <= period_s * sc10_r;

      lim12_r       <= lim11_r;
      ma12_r        <= na11_r[55:16];
      mb12_r        <= nb11_r[55:16];
      mc12_r        <= nc11_r[55:16];
      fa12_r.nonpos <= na11_r[55] || (na11_r == '0);
      fb12_r.nonpos <= nb11_r[55] || (nb11_r == '0);
      fc12_r.nonpos <= nc11_r[55] || (nc11_r == '0);
      fa12_r.over   <= na11_r[55:16] >= vs_full;
      fb12_r.over   <= nb11_r[55:16] >= vs_full;
      fc12_r.over   <= nc11_r[55:16] >= vs_full;
    end
  end

  // duty division
  cmp_tag_t    ca_tag_in;
  cmp_tag_t    ca_tag;
  cmp_flag_t   cb_flag;
  cmp_flag_t   cc_flag;
  logic        cmp_valid;
  logic [15:0] quo_a;
  logic [15:0] quo_b;
  logic [15:0] quo_c;

  assign ca_tag_in.limited = lim12_r;
  assign ca_tag_in.flag    = fa12_r;

  pvpc_div #(
    .NUM_W(40),
    .DEN_W(15),
    .QUO_W(16),
    .TAG_W($bits(cmp_tag_t))
  ) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (v12_r),
    .in_num   (ma12_r),
    .in_den   (vs),
    .in_tag   (ca_tag_in),
    .out_valid(cmp_valid),
    .out_quo  (quo_a),
    .out_tag  (ca_tag)
  );

  pvpc_div #(
    .NUM_W(40),
    .DEN_W(15),
    .QUO_W(16),
    .TAG_W($bits(cmp_flag_t))
  ) u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (v12_r),
    .in_num   (mb12_r),
    .in_den   (vs),
    .in_tag   (fb12_r),
    .out_valid(),
    .out_quo  (quo_b),
    .out_tag  (cb_flag)
  );

  pvpc_div #(
    .NUM_W(40),
    .DEN_W(15),
    .QUO_W(16),
    .TAG_W($bits(cmp_flag_t))
  ) u_div_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (v12_r),
    .in_num   (mc12_r),
    .in_den   (vs),
    .in_tag   (fc12_r),
    .out_valid(),
    .out_quo  (quo_c),
    .out_tag  (cc_flag)
  );

  function automatic logic [15:0] clamp_cmp(input cmp_flag_t f, input logic [15:0] quo,
                                            input logic [15:0] per);
    logic [15:0] c;
    if (f.nonpos) begin
      c = '0;
    end else if (f.over || (quo > per)) begin
      c = per;
    end else begin
      c = quo;
    end
    return c;
  endfunction

  result_t res;

  assign res.compare_a = clamp_cmp(ca_tag.flag, quo_a, period_r);
  assign res.compare_b = clamp_cmp(cb_flag, quo_b, period_r);
  assign res.compare_c = clamp_cmp(cc_flag, quo_c, period_r);
  assign res.limited   = ca_tag.limited;

  // output register with skid entry
  logic    out_valid_r;
  result_t out_r;
  result_t skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      if (advance && cmp_valid) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_r        <= skid_r;
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_r       <= res;
      out_valid_r <= advance && cmp_valid;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_compare_a      = out_r.compare_a;
  assign out_compare_b      = out_r.compare_b;
  assign out_compare_c      = out_r.compare_c;
  assign out_vector_limited = out_r.limited;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the phase voltage to PWM compare pipeline.
// ----------------------------------------------------------------------------
// Drives d/q voltage commands and angles under random valid/ready gaps.
// Each accepted, unpinned beat is run through an in-bench model of the block:
// vector limit, table sine/cosine, inverse Park, inverse Clarke and the
// compare quantizer. Compare counts and the limit flag are checked in order.
// The run steps through several supply/period settings, extremes included.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [15:0] cmp_a;
    logic [15:0] cmp_b;
    logic [15:0] cmp_c;
    logic        lim;
  } duty_t;

  typedef struct {
    logic signed [15:0] d;
    logic signed [15:0] q;
    logic [15:0]        ang;
    bit                 pinned;
    duty_t              res;
  } row_t;

  localparam logic [0:0] REG_SUPPLY = 1'b0;
  localparam logic [0:0] REG_PERIOD = 1'b1;
  localparam int         DRAIN_CYC  = 100;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_volt_d = '0;
  logic signed [15:0] in_volt_q = '0;
  logic [15:0]        in_elec_angle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_compare_a;
  logic [15:0]        out_compare_b;
  logic [15:0]        out_compare_c;
  logic               out_vector_limited;

  longint  sin_tab [1024];
  longint  supply_m = 3072;
  longint  period_m = 1000;
  duty_t   duty_q [$];
  int      beats_in = 0;
  int      errors = 0;
  int      in_idle_pct = 13;
  int      out_idle_pct = 13;
  bit      pin_now = 1'b0;
  duty_t   pin_res;

  phase_voltage_to_pwm_compare u_dut (.*);

  always #5 clk = ~clk;

  function automatic longint quarter_wave(longint unsigned r);
    longint unsigned x, x2, term;
    longint          acc;
    x    = (r * 64'd6746518852) >> 10;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 16384) / 32768;
    return (acc > 32768) ? 64'sd32768 : acc;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint scale_to_limit(longint v, longint vs, longint unsigned root);
    longint unsigned mag;
    longint          s;
    mag = (v < 0) ? -v : v;
    s   = longint'((mag * vs * 65536) / root);
    return (v < 0) ? -s : s;
  endfunction

  function automatic logic [15:0] quantize(longint x48, longint vs, longint p);
    longint y, n, c;
    y = x48 / 64'sd16777216;
    n = p * (y + vs * 32768);
    if (n <= 0) return '0;
    c = n / (vs * 65536);
    if (c > p) c = p;
    return c[15:0];
  endfunction

  function automatic duty_t phase_duty(logic signed [15:0] d_in, logic signed [15:0] q_in,
                                       logic [15:0] ang);
    longint          d, q, vs, mag2, dv, qv, sn, cs, alpha, beta;
    longint unsigned root;
    int              idx;
    duty_t           r;
    d     = d_in;
    q     = q_in;
    vs    = (supply_m == 0) ? 1 : supply_m;
    mag2  = d * d + q * q;
    r.lim = (3 * mag2 > vs * vs);
    if (r.lim) begin
      root = int_sqrt(longint'(3 * mag2) * 65536);
      dv   = scale_to_limit(d, vs, root);
      qv   = scale_to_limit(q, vs, root);
    end else begin
      dv = d * 256;
      qv = q * 256;
    end
    idx     = int'(ang >> 6);
    sn      = sin_tab[idx];
    cs      = sin_tab[(idx + 256) % 1024];
    alpha   = dv * cs - qv * sn;
    beta    = dv * sn + qv * cs;
    r.cmp_a = quantize(alpha * 131072, vs, period_m);
    r.cmp_b = quantize(-alpha * 65536 + beta * 113512, vs, period_m);
    r.cmp_c = quantize(-alpha * 65536 - beta * 113512, vs, period_m);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      duty_q.push_back(pin_now ? pin_res : phase_duty(in_volt_d, in_volt_q, in_elec_angle));
      beats_in <= beats_in + 1;
    end
  end

  always @(posedge clk) begin
    duty_t want;
    if (rst_n && out_valid && out_ready) begin
      if (duty_q.size() == 0) begin
        $error("unexpected beat: compare_a %0d", out_compare_a);
        errors++;
      end else begin
        want = duty_q.pop_front();
        if (out_compare_a !== want.cmp_a) begin
          $error("compare_a exp %0d got %0d", want.cmp_a, out_compare_a);
          errors++;
        end
        if (out_compare_b !== want.cmp_b) begin
          $error("compare_b exp %0d got %0d", want.cmp_b, out_compare_b);
          errors++;
        end
        if (out_compare_c !== want.cmp_c) begin
          $error("compare_c exp %0d got %0d", want.cmp_c, out_compare_c);
          errors++;
        end
        if (out_vector_limited !== want.lim) begin
          $error("vector_limited exp %0d got %0d", want.lim, out_vector_limited);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  task automatic send_beat(logic signed [15:0] d, logic signed [15:0] q, logic [15:0] ang,
                           bit pinned, duty_t res);
    int seen;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_volt_d     = d;
    in_volt_q     = q;
    in_elec_angle = ang;
    pin_now       = pinned;
    pin_res       = res;
    seen          = beats_in;
    do @(negedge clk); while (beats_in == seen);
    pin_now = 1'b0;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_SUPPLY) supply_m = val[14:0];
    else period_m = val;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (duty_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_volt();
    int lim;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: begin
        lim = int'(((supply_m == 0) ? 1 : supply_m) / 2 + 1);
        return 16'(int'($urandom_range(0, 2 * lim)) - lim);
      end
      2: return 16'(int'($urandom_range(0, 128)) - 64);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  initial begin
    row_t  dir [$];
    duty_t none;
    int    sup_set [7];
    int    per_set [7];

    for (int k = 0; k < 1024; k++) begin
      case (k / 256)
        0: sin_tab[k] = quarter_wave(k % 256);
        1: sin_tab[k] = quarter_wave(256 - k % 256);
        2: sin_tab[k] = -quarter_wave(k % 256);
        default: sin_tab[k] = -quarter_wave(256 - k % 256);
      endcase
    end
    none = '0;

    dir.push_back('{16'sd0, 16'sd0, 16'h0000, 1'b1, '{16'd500, 16'd500, 16'd500, 1'b0}});
    dir.push_back('{16'sd0, 16'sd0, 16'hffff, 1'b1, '{16'd500, 16'd500, 16'd500, 1'b0}});
    dir.push_back('{16'sh7fff, 16'sd0, 16'h0000, 1'b0, none});
    dir.push_back('{16'sh8000, 16'sh8000, 16'hffff, 1'b0, none});
    dir.push_back('{16'sd0, 16'sh7fff, 16'h4000, 1'b0, none});
    dir.push_back('{16'sh8000, 16'sh7fff, 16'h8000, 1'b0, none});
    dir.push_back('{16'sd1773, 16'sd0, 16'h0000, 1'b0, none});
    dir.push_back('{16'sd1774, 16'sd0, 16'h0000, 1'b0, none});
    dir.push_back('{16'sd0, -16'sd1774, 16'hc000, 1'b0, none});
    dir.push_back('{16'sd886, 16'sd1500, 16'h1234, 1'b0, none});
    dir.push_back('{16'sd100, -16'sd200, 16'h3039, 1'b0, none});
    dir.push_back('{-16'sd1000, 16'sd1000, 16'h003f, 1'b0, none});
    dir.push_back('{-16'sd1000, 16'sd1000, 16'h0040, 1'b0, none});
    dir.push_back('{16'sh5555, 16'shaaaa, 16'hffc0, 1'b0, none});
    dir.push_back('{-16'sd1, 16'sd1, 16'h5555, 1'b0, none});
    dir.push_back('{16'sd1536, 16'sd0, 16'h0000, 1'b0, none});

    sup_set = '{3072, 0, 32767, 1, 3072, $urandom_range(1, 32767), $urandom_range(1, 4096)};
    per_set = '{1000, 0, 65535, 1, 1000, $urandom_range(1, 65535), $urandom_range(1, 2000)};

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir[i]) send_beat(dir[i].d, dir[i].q, dir[i].ang, dir[i].pinned, dir[i].res);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      write_reg(REG_SUPPLY, 16'(sup_set[ph]));
      write_reg(REG_PERIOD, 16'(per_set[ph]));
      in_idle_pct  = (ph == 3) ? 0 : 13;
      out_idle_pct = (ph == 3) ? 0 : 13;
      if (ph > 0)
        foreach (dir[i]) send_beat(dir[i].d, dir[i].q, dir[i].ang, 1'b0, none);
      repeat (175) send_beat(rand_volt(), rand_volt(), 16'($urandom), 1'b0, none);
    end
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
design/pvpc_pkg.sv
design/pvpc_sine_rom.sv
design/pvpc_isqrt.sv
design/pvpc_div.sv
design/phase_voltage_to_pwm_compare.sv
sim/tb.sv
